// ===== sv/bfsa_pkg.sv =====
// Shared types and constants of the best-fit segment allocator.
// No dependencies.
package bfsa_pkg;
	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 20;
	localparam int ID_W   = 16;
	localparam int SIZE_W = 21;
	localparam int TIME_W = 24;
	localparam int POS_W  = 20;
	localparam int CNT_W  = 5;
	localparam int ST_W   = 3;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_REMOVE  = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_COMPACT = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NOFIT   = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFND  = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP     = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
endpackage

// ===== sv/best_fit_segment_allocator_top.sv =====
// Best-fit segment allocator: top level, table and sequencer.
// Depends on bfsa_pkg and bfsa_minscan.
//
// Keeps up to MAX_SEGMENTS segments in a memory of total_size units and
// returns one result transaction per input transaction. Every operation first
// walks the table once (S_SCAN), and S_DONE then forms the result. Compact,
// and an allocate that passes its checks, then walk the segments in address
// order, each step being one successor search through the shared scan unit:
// a start state (S_WALK), then the scan of every entry (S_STEP). There is one
// step per live segment plus one; allocate, which always has a free entry, takes
// at most N steps. Gaps are never stored: they follow from the table. The input
// side is not ready while an item is in work, nor while a configuration write
// is offered; the result sits in an output register until taken. A write to
// total_size clamps it into 1..2^ADDR_BITS and empties the table.
module best_fit_segment_allocator_top #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfsa_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [bfsa_pkg::ID_W-1:0]      proc_id,
	input  logic [bfsa_pkg::SIZE_W-1:0]    proc_size,
	input  logic [bfsa_pkg::TIME_W-1:0]    proc_time,
	input  logic [bfsa_pkg::TIME_W-1:0]    elapsed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bfsa_pkg::ST_W-1:0]      status,
	output logic [bfsa_pkg::POS_W-1:0]     position,
	output logic [bfsa_pkg::SIZE_W-1:0]    free_space,
	output logic [bfsa_pkg::CNT_W-1:0]     removed_count
);
	import bfsa_pkg::*;
	localparam int N  = MAX_SEGMENTS;
	localparam int AW = ADDR_BITS;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N+1);
	localparam logic [AW:0] LIMIT = (AW+1)'(1) << AW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1; // linear pass: owner, slot, ages
	localparam logic [2:0] S_WALK = 3'd2; // successor searches
	localparam logic [2:0] S_STEP = 3'd3; // consume one search result
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [AW:0]       total_q;
	logic [SIZE_W-1:0] free_q;
	logic [N-1:0]      vld_q;
	logic [ID_W-1:0]   own_q [N];
	logic [AW:0]       base_q [N];
	logic [SIZE_W-1:0] len_q [N];
	logic [TIME_W-1:0] rem_q [N];

	logic [1:0]        op_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] el_q;
	logic [CW-1:0]     cnt_q;
	logic              hit_q, slot_ok_q;
	logic [IW-1:0]     hit_idx_q, slot_q;
	logic [CNT_W-1:0]  rm_q;
	logic              first_q, bfound_q;
	logic [AW:0]       cur_q, bound_q, bgap_q, bpos_q;

	logic [ST_W-1:0]   st_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  rmo_q;
	logic              ov_q;

	// scan unit
	logic              ms_start, ms_done, ms_found;
	logic [CW-1:0]     ms_idx;
	logic [IW-1:0]     ms_best;
	logic [IW-1:0]     ms_rd;
	assign ms_rd = ms_idx[IW-1:0];

	bfsa_minscan #(.N(N), .AW(AW)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(ms_start), .bound(bound_q),
		.first(first_q),
		.ent_valid((ms_idx != CW'(N)) && vld_q[ms_rd]),
		.ent_base(base_q[ms_rd]),
		.idx(ms_idx), .done(ms_done), .found(ms_found), .best_idx(ms_best)
	);

	// a configuration write wins the idle cycle, so the input holds off then
	assign in_ready   = (state_q == S_IDLE) && !ov_q && !cfg_valid;
	assign cfg_ready  = (state_q == S_IDLE) && !ov_q;
	assign out_valid  = ov_q;
	assign status     = st_q;
	assign position   = pos_q;
	assign free_space = free_q;
	assign removed_count = rmo_q;

	logic [IW-1:0] si;
	logic [TIME_W-1:0] aged;
	logic [AW:0] seg_end, gap, end_pt;
	logic [AW:0] cfg_clamp;
	assign si   = cnt_q[IW-1:0];
	assign aged = (rem_q[si] > el_q) ? rem_q[si] - el_q : '0;
	assign end_pt  = ms_found ? base_q[ms_best] : total_q;
	assign gap     = (end_pt > cur_q) ? end_pt - cur_q : '0;
	assign seg_end = base_q[ms_best] + (AW+1)'(len_q[ms_best]);
	always_comb begin
		cfg_clamp = (AW+1)'(cfg_data);
		if (cfg_data == '0) cfg_clamp = (AW+1)'(1);
		else if ({1'b0, cfg_data} > (SIZE_W+1)'(LIMIT)) cfg_clamp = LIMIT;
	end
	assign ms_start = (state_q == S_WALK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= LIMIT;
			free_q  <= SIZE_W'(LIMIT);
			vld_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						total_q <= cfg_clamp;
						free_q  <= SIZE_W'(cfg_clamp);
						vld_q   <= '0;
					end else if (in_valid && in_ready) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == CW'(N)) begin
						priority if (op_q == OP_ALLOC) begin
							if (hit_q || !slot_ok_q || size_q == '0 || size_q > free_q)
								state_q <= S_DONE;
							else
								state_q <= S_WALK;
						end else if (op_q == OP_COMPACT) begin
							state_q <= S_WALK;
						end else begin
							if (op_q == OP_REMOVE && hit_q) begin
								vld_q[hit_idx_q] <= 1'b0;
								free_q <= free_q + len_q[hit_idx_q];
							end
							state_q <= S_DONE;
						end
					end else if (op_q == OP_ADVANCE && vld_q[si] && aged == '0) begin
						vld_q[si] <= 1'b0;
						free_q    <= free_q + len_q[si];
					end
				end
				S_WALK: state_q <= S_STEP;
				S_STEP: begin
					if (ms_done) begin
						if (!ms_found) begin
							state_q <= S_DONE;
							if (op_q == OP_ALLOC && (bfound_q ||
									(gap >= (AW+1)'(size_q))))
								vld_q[slot_q] <= 1'b1;
							if (op_q == OP_ALLOC && (bfound_q ||
									(gap >= (AW+1)'(size_q))))
								free_q <= free_q - size_q;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					ov_q    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	logic fits;
	assign fits = gap >= (AW+1)'(size_q) && (!bfound_q || gap < bgap_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= op; id_q <= proc_id; size_q <= proc_size;
				time_q <= proc_time; el_q <= elapsed;
				cnt_q <= '0; hit_q <= 1'b0; slot_ok_q <= 1'b0; rm_q <= '0;
				first_q <= 1'b1; bfound_q <= 1'b0; cur_q <= '0; bound_q <= '0;
			end
			S_SCAN: begin
				if (cnt_q != CW'(N)) begin
					cnt_q <= cnt_q + 1'b1;
					if (vld_q[si] && own_q[si] == id_q && !hit_q) begin
						hit_q <= 1'b1; hit_idx_q <= si;
					end
					if (!vld_q[si] && !slot_ok_q) begin
						slot_ok_q <= 1'b1; slot_q <= si;
					end
					if (op_q == OP_ADVANCE && vld_q[si]) begin
						rem_q[si] <= aged;
						if (aged == '0) rm_q <= rm_q + 1'b1;
					end
				end
			end
			S_STEP: begin
				if (ms_done) begin
					if (op_q == OP_ALLOC && fits) begin
						bfound_q <= 1'b1; bgap_q <= gap; bpos_q <= cur_q;
					end
					if (ms_found) begin
						first_q <= 1'b0;
						bound_q <= base_q[ms_best];
						if (op_q == OP_COMPACT) begin
							base_q[ms_best] <= cur_q;
							cur_q <= cur_q + (AW+1)'(len_q[ms_best]);
						end else begin
							cur_q <= seg_end;
						end
					end else if (op_q == OP_ALLOC && (bfound_q || fits)) begin
						own_q[slot_q]  <= id_q;
						base_q[slot_q] <= fits ? cur_q : bpos_q;
						len_q[slot_q]  <= size_q;
						rem_q[slot_q]  <= time_q;
						bpos_q <= fits ? cur_q : bpos_q;
						bfound_q <= 1'b1;
					end
				end
			end
			S_DONE: begin
				rmo_q <= (op_q == OP_ADVANCE) ? rm_q : '0;
				pos_q <= '0;
				priority if (op_q == OP_ALLOC) begin
					if (hit_q) st_q <= ST_DUP;
					else if (!slot_ok_q) st_q <= ST_FULL;
					else if (!bfound_q) st_q <= ST_NOFIT;
					else begin st_q <= ST_OK; pos_q <= POS_W'(bpos_q); end
				end else if (op_q == OP_REMOVE) begin
					st_q <= hit_q ? ST_OK : ST_NOTFND;
				end else begin
					st_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	// A walk into S_STEP always follows a scan start.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |=> state_q == S_STEP) else $error("walk sequencing");
	// Free units never exceed the managed size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(AW+1)'(free_q) <= total_q) else $error("free units overflow");
	// No input accepted while a result is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !in_ready) else $error("accept with pending result");
endmodule

// ===== sv/bfsa_minscan.sv =====
// Address-order successor search: one entry examined per cycle.
// Finds the valid entry with the smallest base strictly above a
// bound, or any base when first is set. Depends on bfsa_pkg.
module bfsa_minscan #(
	parameter int N  = bfsa_pkg::MAX_SEGMENTS_DEF,
	parameter int AW = bfsa_pkg::ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [AW:0]           bound,
	input  logic                  first,
	input  logic                  ent_valid,
	input  logic [AW:0]           ent_base,
	output logic [$clog2(N+1)-1:0] idx,
	output logic                  done,
	output logic                  found,
	output logic [((N>1)?$clog2(N):1)-1:0] best_idx
);
	import bfsa_pkg::*;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N+1);
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          found_q;
	logic [AW:0]   best_q;
	logic [IW-1:0] bidx_q;
	logic          take;

	assign idx      = cnt_q;
	assign found    = found_q;
	assign best_idx = bidx_q;
	assign done     = busy_q && (cnt_q == CW'(N));
	assign take     = busy_q && (cnt_q != CW'(N)) && ent_valid &&
		(first || ent_base > bound) && (!found_q || ent_base < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == CW'(N)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				if (take) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= ent_base;
			bidx_q <= cnt_q[IW-1:0];
		end
	end
endmodule
